>>> rtl/socks5_reply_checker_assert.svh
// assertion macros used by the reply checker top level
`ifndef SOCKS5_REPLY_CHECKER_ASSERT_SVH
`define SOCKS5_REPLY_CHECKER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define S5RC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define S5RC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/s5rc_pkg.sv
// types and codes for the socks5 reply checker
package s5rc_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_LINK  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_METH = 4'd1,
    PH_AUTH = 4'd2,
    PH_HDR  = 4'd3,
    PH_NLEN = 4'd4,
    PH_ADDR = 4'd5,
    PH_PORT = 4'd6,
    PH_DONE = 4'd7,
    PH_FAIL = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE      = 2'd0,
    ST_BUSY      = 2'd1,
    ST_CONNECTED = 2'd2,
    ST_FAILED    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_LINK      = 3'd1,
    ERR_GREET     = 3'd2,
    ERR_METHOD    = 3'd3,
    ERR_AUTH      = 3'd4,
    ERR_VER       = 3'd5,
    ERR_REFUSED   = 3'd6,
    ERR_MALFORMED = 3'd7
  } err_t;

  localparam logic [7:0] SOCKS_VER     = 8'h05;
  localparam logic [7:0] METHOD_NOAUTH = 8'h00;
  localparam logic [7:0] METHOD_USERPW = 8'h02;
  localparam logic [7:0] AUTH_VER      = 8'h01;
  localparam logic [7:0] AUTH_OK       = 8'h00;
  localparam logic [7:0] REP_OK        = 8'h00;
  localparam logic [7:0] ATYP_IPV4     = 8'h01;
  localparam logic [7:0] ATYP_NAME     = 8'h03;
  localparam logic [7:0] ATYP_IPV6     = 8'h04;
  localparam logic [7:0] LEN_IPV4      = 8'd4;
  localparam logic [7:0] LEN_IPV6      = 8'd16;
  localparam logic [7:0] LEN_PAIR      = 8'd2;
  localparam logic [7:0] LEN_HDR       = 8'd4;
  localparam logic [7:0] LEN_ONE       = 8'd1;

  localparam int unsigned RESULT_PAD = 3;

  // status in the low bits, reply code on top
  typedef struct packed {
    logic [7:0] reply_code;
    err_t       error_code;
    status_t    status;
  } result_t;

endpackage

>>> rtl/socks5_reply_checker.sv
// top level of the socks5 reply checker
// Checks the bytes a SOCKS5 proxy returns during a CONNECT handshake and
// reports one status beat per input beat. Input beats carry an opcode in
// tuser (start, received byte, link failure, no-op) and the byte in tdata.
// One beat is taken every cycle while the result can move. The input register
// loads at the accepting edge and the parser's state update loads the result
// register when the beat can leave the input register, so a result passes the
// input register and then the result register before it is on m_axis. The parser
// state update is the only loop, so back-to-back beats run at full rate while the
// output is not stalled; while m_axis_tready is low the block holds two beats and
// then drops s_axis_tready until the result moves.
// auth_offered is written through cfg_wr_en/cfg_wr_data; write it only while idle (not enforced by the block).
module socks5_reply_checker
  import s5rc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,     // auth_offered
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser,    // [1:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata     // [1:0] status, [4:2] error_code, [12:5] reply_code
);

`include "socks5_reply_checker_assert.svh"

  logic       auth_offered;
  logic       in_valid;
  opcode_t    in_op;
  logic [7:0] in_byte;
  logic       out_valid;
  result_t    out_result;
  result_t    step_result;
  logic       advance;
  logic       step_en;

  assign advance       = !out_valid || m_axis_tready;
  assign step_en       = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{RESULT_PAD{1'b0}}, out_result};

  always_ff @(posedge clk) begin
    if (rst) begin
      auth_offered <= 1'b0;
    end else if (cfg_wr_en) begin
      auth_offered <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op   <= opcode_t'(s_axis_tuser);
      in_byte <= s_axis_tdata;
    end
  end

  s5rc_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .step_en      (step_en),
    .op           (in_op),
    .rx_byte      (in_byte),
    .auth_offered (auth_offered),
    .result       (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_result <= step_result;
    end
  end

  // a beat in the input register that is free to move lands in the result register
  `S5RC_ASSERT_NEXT(a_step_fills_out, clk, rst, step_en, out_valid,
                    "stepped beat did not reach the result register")
  // an accepted beat always occupies the input register next cycle
  `S5RC_ASSERT_NEXT(a_accept_fills_in, clk, rst, s_axis_tvalid && s_axis_tready, in_valid,
                    "accepted beat lost from the input register")
  // only a failed status carries an error, only a refusal carries a reply code
  `S5RC_ASSERT_NOW(a_err_only_on_fail, clk, rst,
                   out_valid && out_result.status != ST_FAILED,
                   out_result.error_code == ERR_NONE && out_result.reply_code == 8'h00,
                   "error reported without a failed status")
  `S5RC_ASSERT_NOW(a_reply_only_on_refusal, clk, rst,
                   out_valid && out_result.reply_code != 8'h00,
                   out_result.error_code == ERR_REFUSED,
                   "reply code reported without a refusal")

endmodule

>>> rtl/s5rc_parser.sv
// handshake parser state and per-beat update
module s5rc_parser
  import s5rc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step_en,
  input  opcode_t    op,
  input  logic [7:0] rx_byte,
  input  logic       auth_offered,
  output result_t    result
);

  phase_t      phase, phase_next;
  logic [23:0] held_bytes, held_bytes_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  last_reply, last_reply_next;
  err_t        err, err_next;
  logic        busy;

  assign busy = (phase == PH_METH) || (phase == PH_AUTH) || (phase == PH_HDR) ||
                (phase == PH_NLEN) || (phase == PH_ADDR) || (phase == PH_PORT);

  always_comb begin
    phase_next      = phase;
    held_bytes_next = held_bytes;
    bytes_left_next = bytes_left;
    last_reply_next = last_reply;
    err_next        = err;
    case (op)
      OP_START: begin
        phase_next      = PH_METH;
        bytes_left_next = LEN_PAIR;
        held_bytes_next = '0;
        last_reply_next = '0;
      end
      OP_BYTE: begin
        if (busy) begin
          if (phase != PH_NLEN && bytes_left > LEN_ONE) begin
            held_bytes_next = {held_bytes[15:0], rx_byte};
            bytes_left_next = bytes_left - 8'd1;
          end else begin
            // last beat of a unit: check it and move on
            held_bytes_next = '0;
            bytes_left_next = '0;
            case (phase)
              PH_METH: begin
                if (held_bytes[7:0] != SOCKS_VER) begin
                  phase_next = PH_FAIL;
                  err_next   = ERR_GREET;
                end else if (rx_byte == METHOD_USERPW && auth_offered) begin
                  phase_next      = PH_AUTH;
                  bytes_left_next = LEN_PAIR;
                end else if (rx_byte == METHOD_NOAUTH) begin
                  phase_next      = PH_HDR;
                  bytes_left_next = LEN_HDR;
                end else begin
                  phase_next = PH_FAIL;
                  err_next   = ERR_METHOD;
                end
              end
              PH_AUTH: begin
                if (held_bytes[7:0] != AUTH_VER || rx_byte != AUTH_OK) begin
                  phase_next = PH_FAIL;
                  err_next   = ERR_AUTH;
                end else begin
                  phase_next      = PH_HDR;
                  bytes_left_next = LEN_HDR;
                end
              end
              PH_HDR: begin
                if (held_bytes[23:16] != SOCKS_VER) begin
                  phase_next = PH_FAIL;
                  err_next   = ERR_VER;
                end else if (held_bytes[15:8] != REP_OK) begin
                  phase_next      = PH_FAIL;
                  err_next        = ERR_REFUSED;
                  last_reply_next = held_bytes[15:8];
                end else if (held_bytes[7:0] != 8'h00) begin
                  phase_next = PH_FAIL;
                  err_next   = ERR_MALFORMED;
                end else if (rx_byte == ATYP_IPV4) begin
                  phase_next      = PH_ADDR;
                  bytes_left_next = LEN_IPV4;
                end else if (rx_byte == ATYP_IPV6) begin
                  phase_next      = PH_ADDR;
                  bytes_left_next = LEN_IPV6;
                end else if (rx_byte == ATYP_NAME) begin
                  phase_next      = PH_NLEN;
                  bytes_left_next = LEN_ONE;
                end else begin
                  phase_next = PH_FAIL;
                  err_next   = ERR_MALFORMED;
                end
              end
              PH_NLEN: begin
                // empty name goes straight to the port
                if (rx_byte == 8'h00) begin
                  phase_next      = PH_PORT;
                  bytes_left_next = LEN_PAIR;
                end else begin
                  phase_next      = PH_ADDR;
                  bytes_left_next = rx_byte;
                end
              end
              PH_ADDR: begin
                phase_next      = PH_PORT;
                bytes_left_next = LEN_PAIR;
              end
              default: begin
                phase_next = PH_DONE;
              end
            endcase
          end
        end
      end
      OP_LINK: begin
        if (busy) begin
          phase_next      = PH_FAIL;
          err_next        = ERR_LINK;
          held_bytes_next = '0;
          bytes_left_next = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.status     = ST_BUSY;
    result.error_code = ERR_NONE;
    result.reply_code = '0;
    case (phase_next)
      PH_IDLE: result.status = ST_IDLE;
      PH_DONE: result.status = ST_CONNECTED;
      PH_FAIL: begin
        result.status     = ST_FAILED;
        result.error_code = err_next;
        if (err_next == ERR_REFUSED) begin
          result.reply_code = last_reply_next;
        end
      end
      default: result.status = ST_BUSY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      held_bytes <= '0;
      bytes_left <= '0;
      last_reply <= '0;
      err        <= ERR_NONE;
    end else if (step_en) begin
      phase      <= phase_next;
      held_bytes <= held_bytes_next;
      bytes_left <= bytes_left_next;
      last_reply <= last_reply_next;
      err        <= err_next;
    end
  end

endmodule

>>> verif/tb.sv
// self-checking testbench for the socks5 reply checker
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import s5rc_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 6;
  localparam logic [7:0] RSV_BYTE = 8'h00;

  typedef struct {
    opcode_t    op;
    logic [7:0] data;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
  logic [1:0]  s_axis_tuser = 2'd0;    // [1:0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [1:0] status, [4:2] error_code, [12:5] reply_code

  socks5_reply_checker u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #10 clk = ~clk;

  // parser mirror
  logic        auth_cfg = 1'b0;
  phase_t      sess_phase = PH_IDLE;
  logic [23:0] sess_held = '0;
  logic [7:0]  sess_left = '0;
  logic [7:0]  sess_refusal = '0;

  result_t expected_status[$];
  beat_t   script[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int idle_count = 0;

  int mismatches = 0;
  int beats_sent = 0;
  int results_checked = 0;
  int handshakes = 0;
  int connects = 0;
  int cfg_writes = 0;
  int fail_kinds[8];

  function automatic void goto_stage(input phase_t p, input logic [7:0] n);
    sess_phase = p;
    sess_left = n;
    sess_held = '0;
  endfunction

  function automatic void fail_session(input err_t e);
    sess_phase = PH_FAIL;
    sess_held = {21'd0, e};
    sess_left = '0;
  endfunction

  function automatic void take_rx_byte(input logic [7:0] b);
    if (sess_phase < PH_METH || sess_phase > PH_PORT) return;
    // collect bytes until the last one of the unit arrives
    if (sess_phase != PH_NLEN && sess_left > 8'd1) begin
      sess_held = {sess_held[15:0], b};
      sess_left = sess_left - 8'd1;
      return;
    end
    case (sess_phase)
      PH_METH: begin
        if (sess_held[7:0] != SOCKS_VER) fail_session(ERR_GREET);
        else if (b == METHOD_USERPW && auth_cfg) goto_stage(PH_AUTH, LEN_PAIR);
        else if (b == METHOD_NOAUTH) goto_stage(PH_HDR, LEN_HDR);
        else fail_session(ERR_METHOD);
      end
      PH_AUTH: begin
        if (sess_held[7:0] != AUTH_VER || b != AUTH_OK) fail_session(ERR_AUTH);
        else goto_stage(PH_HDR, LEN_HDR);
      end
      PH_HDR: begin
        if (sess_held[23:16] != SOCKS_VER) begin
          fail_session(ERR_VER);
        end else if (sess_held[15:8] != REP_OK) begin
          sess_refusal = sess_held[15:8];
          fail_session(ERR_REFUSED);
        end else if (sess_held[7:0] != RSV_BYTE) begin
          fail_session(ERR_MALFORMED);
        end else if (b == ATYP_IPV4) begin
          goto_stage(PH_ADDR, LEN_IPV4);
        end else if (b == ATYP_IPV6) begin
          goto_stage(PH_ADDR, LEN_IPV6);
        end else if (b == ATYP_NAME) begin
          goto_stage(PH_NLEN, LEN_ONE);
        end else begin
          fail_session(ERR_MALFORMED);
        end
      end
      PH_NLEN: begin
        // empty name goes straight to the port
        if (b == 8'd0) goto_stage(PH_PORT, LEN_PAIR);
        else goto_stage(PH_ADDR, b);
      end
      PH_ADDR: goto_stage(PH_PORT, LEN_PAIR);
      default: goto_stage(PH_DONE, 8'd0);
    endcase
  endfunction

  task automatic advance_parser(input opcode_t op, input logic [7:0] b, output result_t r);
    phase_t was;
    was = sess_phase;
    case (op)
      OP_START: begin
        goto_stage(PH_METH, LEN_PAIR);
        sess_refusal = 8'h00;
        handshakes++;
      end
      OP_BYTE: take_rx_byte(b);
      OP_LINK: if (sess_phase >= PH_METH && sess_phase <= PH_PORT) fail_session(ERR_LINK);
      default: ;
    endcase
    r = '0;
    case (sess_phase)
      PH_IDLE: r.status = ST_IDLE;
      PH_DONE: r.status = ST_CONNECTED;
      PH_FAIL: begin
        r.status = ST_FAILED;
        r.error_code = err_t'(sess_held[2:0]);
        if (r.error_code == ERR_REFUSED) r.reply_code = sess_refusal;
      end
      default: r.status = ST_BUSY;
    endcase
    if (sess_phase == PH_DONE && was != PH_DONE) connects++;
    if (sess_phase == PH_FAIL && was != PH_FAIL) fail_kinds[sess_held[2:0]]++;
  endtask

  // one beat into the block, possibly with a random gap in front of it
  task automatic send_beat(input opcode_t op, input logic [7:0] d);
    result_t want;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= d;
    do @(posedge clk); while (!s_axis_tready);
    advance_parser(op, d, want);
    expected_status.insert(expected_status.size(), want);
    beats_sent++;
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_auth(input logic v);
    wait_drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    auth_cfg = v;
    cfg_writes++;
  endtask

  function automatic void add_beat(input opcode_t op, input logic [7:0] d);
    script.insert(script.size(), beat_t'{op, d});
  endfunction

  // a proxy reply sequence, mostly legal, sometimes broken on purpose
  task automatic build_session(input bit clean);
    logic [7:0] meth;
    int alen;
    int rep_at;
    int pos;
    script.delete();
    add_beat(OP_START, 8'($urandom_range(255)));
    add_beat(OP_BYTE, SOCKS_VER);
    meth = (auth_cfg && $urandom_range(1)) ? METHOD_USERPW : METHOD_NOAUTH;
    add_beat(OP_BYTE, meth);
    if (meth == METHOD_USERPW) begin
      add_beat(OP_BYTE, AUTH_VER);
      add_beat(OP_BYTE, AUTH_OK);
    end
    add_beat(OP_BYTE, SOCKS_VER);
    rep_at = script.size();
    add_beat(OP_BYTE, REP_OK);
    add_beat(OP_BYTE, RSV_BYTE);
    case ($urandom_range(2))
      0: begin
        add_beat(OP_BYTE, ATYP_IPV4);
        alen = int'(LEN_IPV4);
      end
      1: begin
        add_beat(OP_BYTE, ATYP_IPV6);
        alen = int'(LEN_IPV6);
      end
      default: begin
        add_beat(OP_BYTE, ATYP_NAME);
        alen = ($urandom_range(49) == 0) ? 255 : int'($urandom_range(12));
        add_beat(OP_BYTE, 8'(alen));
      end
    endcase
    repeat (alen + 2) add_beat(OP_BYTE, 8'($urandom_range(255)));
    if (clean) begin
      if ($urandom_range(9) == 0) begin
        pos = $urandom_range(1, script.size() - 1);
        script.insert(pos, beat_t'{OP_NOP, 8'($urandom_range(255))});
      end
      // traffic after the handshake has finished
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(1, 3))
          add_beat(opcode_t'($urandom_range(1, 3)), 8'($urandom_range(255)));
    end else begin
      case ($urandom_range(5))
        0: begin
          pos = $urandom_range(1, script.size() - 1);
          script[pos].data = 8'($urandom_range(255));
        end
        1: begin
          pos = $urandom_range(1, script.size() - 1);
          while (script.size() > pos) void'(script.pop_back());
          add_beat(OP_LINK, 8'($urandom_range(255)));
        end
        2: begin
          // cut short; the next start lands on a busy parser
          pos = $urandom_range(1, script.size() - 1);
          while (script.size() > pos) void'(script.pop_back());
        end
        3: script[rep_at].data = 8'($urandom_range(1, 255));
        4: script[2].data = $urandom_range(1) ? METHOD_USERPW : 8'($urandom_range(255));
        default: begin
          repeat ($urandom_range(1, 4)) begin
            pos = $urandom_range(0, script.size() - 1);
            script.insert(pos, beat_t'{opcode_t'($urandom_range(3)),
                                       8'($urandom_range(255))});
          end
        end
      endcase
    end
  endtask

  task automatic run_sessions(input int n_items);
    int first;
    first = beats_sent;
    while (beats_sent - first < n_items) begin
      build_session($urandom_range(99) < 70);
      foreach (script[i]) send_beat(script[i].op, script[i].data);
    end
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic test_corner_cases();
    set_idling(0, 0);
    write_auth(1'b0);
    send_beat(OP_BYTE, 8'hFF);   // byte while idle
    send_beat(OP_LINK, 8'h00);   // link drop while idle
    send_beat(OP_NOP, 8'hFF);
    send_beat(OP_START, 8'h00);
    send_beat(OP_BYTE, SOCKS_VER);
    send_beat(OP_BYTE, METHOD_NOAUTH);
    send_beat(OP_BYTE, SOCKS_VER);
    send_beat(OP_BYTE, REP_OK);
    send_beat(OP_BYTE, RSV_BYTE);
    send_beat(OP_BYTE, ATYP_NAME);
    send_beat(OP_BYTE, 8'h00);   // empty name, port follows
    send_beat(OP_BYTE, 8'h00);
    send_beat(OP_BYTE, 8'hFF);
    send_beat(OP_BYTE, SOCKS_VER);   // byte while connected
    send_beat(OP_START, 8'hFF);
    send_beat(OP_BYTE, SOCKS_VER);
    send_beat(OP_START, 8'h00);  // restart while busy
    send_beat(OP_BYTE, 8'h04);
    send_beat(OP_BYTE, METHOD_NOAUTH);
    send_beat(OP_LINK, 8'hFF);   // link drop after failure
    send_beat(OP_BYTE, 8'h00);
    send_beat(OP_START, 8'h00);
    send_beat(OP_BYTE, SOCKS_VER);
    send_beat(OP_LINK, 8'h00);
    send_beat(OP_NOP, 8'h00);
  endtask

  task automatic test_full_rate();
    write_auth(1'b1);
    set_idling(0, 0);
    run_sessions(100);
  endtask

  task automatic test_sender_idle();
    write_auth(1'b0);
    set_idling(73, 0);
    run_sessions(100);
  endtask

  task automatic test_receiver_stall();
    write_auth(1'b1);
    set_idling(0, 73);
    run_sessions(100);
  endtask

  task automatic test_mixed_idle();
    write_auth(1'($urandom_range(1)));
    set_idling(22, 22);
    run_sessions(100);
  endtask

  // output held off for a long stretch while beats keep coming
  task automatic test_output_hold();
    write_auth(1'b1);
    set_idling(0, 0);
    hold_req++;
    @(posedge clk);
    run_sessions(60);
  endtask

  // sender stops mid-handshake until every result is back
  task automatic test_drain_pause();
    int half;
    write_auth(1'b0);
    set_idling(22, 22);
    repeat (3) begin
      build_session(1'b1);
      half = script.size() / 2;
      foreach (script[i]) begin
        if (i == half) wait_drain();
        send_beat(script[i].op, script[i].data);
      end
    end
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
      if (expected_status.size() == 0) begin
        $error("result beat 0x%h with nothing expected", m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_status.pop_front();
        results_checked++;
        if (got.status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          mismatches++;
        end
        if (got.error_code != want.error_code) begin
          $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
          mismatches++;
        end
        if (got.reply_code != want.reply_code) begin
          $error("reply_code: expected 0x%h, got 0x%h", want.reply_code, got.reply_code);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved in %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL socks5_reply_checker");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_cases();
    test_full_rate();
    test_sender_idle();
    test_receiver_stall();
    test_mixed_idle();
    test_output_hold();
    test_drain_pause();
    wait_drain();
    $display("covered %0d beats, %0d results, %0d handshakes (%0d connected), %0d cfg writes",
             beats_sent, results_checked, handshakes, connects, cfg_writes);
    $display("failures: link %0d greet %0d method %0d auth %0d ver %0d refused %0d bad %0d",
             fail_kinds[1], fail_kinds[2], fail_kinds[3], fail_kinds[4], fail_kinds[5],
             fail_kinds[6], fail_kinds[7]);
    if (mismatches == 0) begin
      $display("PASS socks5_reply_checker");
    end else begin
      $display("FAIL socks5_reply_checker");
    end
    $finish;
  end

endmodule

>>> socks5_reply_checker.f
+incdir+rtl
rtl/s5rc_pkg.sv
rtl/s5rc_parser.sv
rtl/socks5_reply_checker.sv
verif/tb.sv
